// ===== rtl/tffs_pkg.sv =====
// Shared constants for the triangle fill and frame sampler.
// No dependencies.
`default_nettype none
package tffs_pkg;
   localparam int DEF_WIDTH  = 640;
   localparam int DEF_HEIGHT = 480;
   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/tffs_frame_mem.sv =====
// Single-port frame store: one synchronous write or read per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module tffs_frame_mem #(
   parameter int DEPTH = 307200,
   parameter int AW = 19
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [7:0]    wr_data,
   output logic      [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/triangle_fill_frame_sampler.sv =====
// Triangle fill and frame sampler: top level with the sequencer for fill, read and clear.
// Uses tffs_pkg and tffs_frame_mem.
// Reset starts a clearing pass over all IMAGE_WIDTH*IMAGE_HEIGHT pixels (307200), busy all along.
// A read steps S_DIV, S_RD1, S_RDA, S_RDB, S_INTERP to its rsp_strobe beat in S_OUT (skipping S_RDA to
// S_INTERP when blanked); a fill is busy in S_BOX and S_EDGE, then S_MUL and S_TEST per edge and S_PIX per
// pixel of its clamped box. Start is taken while busy is low. Reset is synchronous; the receiver cannot stall.
`default_nettype none
module triangle_fill_frame_sampler #(
   parameter int IMAGE_WIDTH  = tffs_pkg::DEF_WIDTH,
   parameter int IMAGE_HEIGHT = tffs_pkg::DEF_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [13:0] req_vert_ax,
   input  wire logic [12:0] req_vert_ay,
   input  wire logic [13:0] req_vert_bx,
   input  wire logic [12:0] req_vert_by,
   input  wire logic [13:0] req_vert_cx,
   input  wire logic [12:0] req_vert_cy,
   input  wire logic [7:0]  req_fill_level,
   input  wire logic [17:0] req_sample_pos,
   input  wire logic [8:0]  req_line_index,
   output logic             rsp_strobe,
   output logic [23:0]      rsp_sample_rgb
);
   import tffs_pkg::*;

   localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int XW = 11; // holds up to 2047
   localparam logic [XW-1:0] WMAX = XW'(IMAGE_WIDTH);
   localparam logic [XW-1:0] HMAX = XW'(IMAGE_HEIGHT);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_BOX, S_EDGE, S_PIX, S_MUL, S_TEST,
      S_DIV, S_RD1, S_RDA, S_RDB, S_INTERP, S_OUT
   } state_type;

   state_type state_ff;
   logic [AW-1:0] clr_ff;

   // Latched item.
   logic signed [15:0] vx_ff [3];
   logic signed [15:0] vy_ff [3];
   logic [7:0]  level_ff;
   logic [8:0]  line_ff;

   // Fill scan.
   logic [XW-1:0] x0_ff, x1_ff, y1_ff, x_ff, y_ff;
   logic [1:0]    k_ff;
   logic signed [33:0] prod_a_ff, prod_b_ff;
   logic          inside_ff;

   // Read path.
   logic [22:0]        num_ff;   // dividend, biased by 22*2048 so that it is never negative
   logic signed [17:0] xi_ff;
   logic [7:0]         frac_ff;
   logic [7:0]         p1_ff;
   logic [AW-1:0]      addr_ff;
   logic [23:0]        rgb_ff;

   logic [7:0] rd_data;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wd;

   tffs_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wd), .rd_data(rd_data)
   );

   // Span start/end in pixels from 1/16 coordinates.
   function automatic logic [XW-1:0] span_start(input logic [15:0] m);
      logic [16:0] t;
      t = {1'b0, m} + 17'd23;
      return XW'(t[16:4]);
   endfunction
   function automatic logic [XW-1:0] span_end(input logic [15:0] hi,
                                            input logic [XW-1:0] size);
      logic [16:0] h, t;
      h = {1'b0, hi};
      if (h > {size, 4'd0}) h = 17'({size, 4'd0});
      t = h + 17'd23;
      if (t[16:4] > 13'(size)) return size;
      return XW'(t[16:4]);
   endfunction

   logic [15:0] mnx, mxx, mny, mxy;
   always_comb begin
      mnx = vx_ff[0]; mxx = vx_ff[0]; mny = vy_ff[0]; mxy = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < $signed(mnx)) mnx = vx_ff[i];
         if (vx_ff[i] > $signed(mxx)) mxx = vx_ff[i];
         if (vy_ff[i] < $signed(mny)) mny = vy_ff[i];
         if (vy_ff[i] > $signed(mxy)) mxy = vy_ff[i];
      end
   end

   // Current edge k from vertex k to previous vertex q.
   logic [1:0] q_sel;
   logic signed [16:0] ex, ey, dx, dy;
   always_comb begin
      q_sel = (k_ff == 2'd0) ? 2'd2 : k_ff - 2'd1;
      ex = 17'(vx_ff[q_sel]) - 17'(vx_ff[k_ff]);
      ey = 17'(vy_ff[q_sel]) - 17'(vy_ff[k_ff]);
      dx = $signed({2'b0, x_ff, 4'd8}) - 17'(vx_ff[k_ff]);
      dy = $signed({2'b0, y_ff, 4'd8}) - 17'(vy_ff[k_ff]);
   end

   // Pixel address of (x, y).
   logic [AW-1:0] pix_addr;
   always_comb begin
      pix_addr = AW'(32'(y_ff) * IMAGE_WIDTH + 32'(x_ff));
   end

   // Division by 22 through the reciprocal ceil(2^28 / 22); exact for dividends below 2^25.
   localparam logic [23:0] RECIP22 = 24'd12201612;
   logic [46:0] quo_prod;
   logic [17:0] quo;
   always_comb begin
      quo_prod = 47'(num_ff) * 47'(RECIP22);
      quo = quo_prod[45:28];
   end

   // Linear interpolation.
   logic signed [17:0] tdiff;
   logic [7:0] p2_eff;
   always_comb begin
      p2_eff = (xi_ff + 18'sd1 >= 18'(IMAGE_WIDTH)) ? 8'd0 : rd_data;
      tdiff = (18'($signed({1'b0, p2_eff})) - 18'($signed({1'b0, p1_ff})))
              * $signed({10'd0, frac_ff}) + 18'sd128;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wd = level_ff;
      mem_addr = pix_addr;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1; mem_wd = 8'd0; mem_addr = clr_ff;
      end else if (state_ff == S_PIX && inside_ff) begin
         mem_we = 1'b1;
      end else if (state_ff == S_RDA || state_ff == S_RDB) begin
         mem_addr = addr_ff;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_OUT);
   assign rsp_sample_rgb = rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  vx_ff[0] <= 16'(req_vert_ax); vy_ff[0] <= 16'(req_vert_ay);
                  vx_ff[1] <= 16'(req_vert_bx); vy_ff[1] <= 16'(req_vert_by);
                  vx_ff[2] <= 16'(req_vert_cx); vy_ff[2] <= 16'(req_vert_cy);
                  level_ff <= req_fill_level;
                  line_ff <= req_line_index;
                  // (pos - 2048) * 20 - 2805 + 22 * 2048
                  num_ff <= 23'(req_sample_pos) * 23'd20 + 23'd1291;
                  state_ff <= (req_operation == OP_FILL) ? S_BOX : S_DIV;
               end
            end
            S_BOX: begin
               x0_ff <= span_start(mnx);
               x_ff  <= span_start(mnx);
               y_ff  <= span_start(mny);
               x1_ff <= span_end(mxx, WMAX);
               y1_ff <= span_end(mxy, HMAX);
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               if (y_ff >= y1_ff || x0_ff >= x1_ff) state_ff <= S_IDLE;
               else begin
                  k_ff <= 2'd0; inside_ff <= 1'b1; state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_a_ff <= 34'(ey) * 34'(dx);
               prod_b_ff <= 34'(ex) * 34'(dy);
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if (prod_b_ff < prod_a_ff) inside_ff <= 1'b0;
               if (k_ff != 2'd2) begin
                  k_ff <= k_ff + 2'd1; state_ff <= S_MUL;
               end else begin
                  state_ff <= S_PIX;
               end
            end
            S_PIX: begin
               // The covered pixel is written in this cycle, at the current x and y.
               k_ff <= 2'd0; inside_ff <= 1'b1;
               state_ff <= S_MUL;
               if (x_ff + XW'(1) >= x1_ff) begin
                  x_ff <= x0_ff;
                  y_ff <= y_ff + XW'(1);
                  if (y_ff + XW'(1) >= y1_ff) state_ff <= S_IDLE;
               end else begin
                  x_ff <= x_ff + XW'(1);
               end
            end
            S_DIV: begin
               // The bias adds eight whole pixels to the quotient.
               xi_ff <= $signed(18'(quo[17:8])) - 18'sd8;
               frac_ff <= quo[7:0];
               state_ff <= S_RD1;
            end
            S_RD1: begin
               if (32'(line_ff) >= IMAGE_HEIGHT || xi_ff < -18'sd1
                   || xi_ff >= 18'(IMAGE_WIDTH)) begin
                  rgb_ff <= '0; state_ff <= S_OUT;
               end else begin
                  // On the left edge p1 is padding and both reads go to pixel 0.
                  if (xi_ff < 18'sd0) addr_ff <= AW'(32'(line_ff) * IMAGE_WIDTH);
                  else addr_ff <= AW'(32'(line_ff) * IMAGE_WIDTH + 32'(xi_ff));
                  state_ff <= S_RDA;
               end
            end
            S_RDA: begin
               // p1 address is issued; step to p2 unless it is padding or pixel 0 again.
               if (xi_ff >= 18'sd0 && xi_ff + 18'sd1 < 18'(IMAGE_WIDTH)) begin
                  addr_ff <= addr_ff + AW'(1);
               end
               state_ff <= S_RDB;
            end
            S_RDB: begin
               p1_ff <= (xi_ff < 18'sd0) ? 8'd0 : rd_data;
               state_ff <= S_INTERP;
            end
            S_INTERP: begin
               rgb_ff <= {3{8'(p1_ff + 8'(tdiff >>> 8))}};
               state_ff <= S_OUT;
            end
            S_OUT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_start_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> busy) else $error("busy low in clear");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held");
   a_no_write_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !mem_we) else $error("write during read");
endmodule
`default_nettype wire
